// ===== src/mixed_radix_range_odometer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mixed radix range odometer
// Clocked on clk_i; only MRO_ASSERT is off in reset; empty if SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_RANGE_ODOMETER_ASSERT_SVH
`define MIXED_RADIX_RANGE_ODOMETER_ASSERT_SVH

`ifndef SYNTH
`define MRO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("odometer assertion failed");
`define MRO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("odometer assertion failed");
`else
`define MRO_ASSERT(lbl, prop)
`define MRO_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/mro_pkg.sv =====
// ----------------------------------------------------------------------------
// mro_pkg
// Shared types and constants of the mixed radix range odometer.
// ----------------------------------------------------------------------------
`default_nettype none

package mro_pkg;

  localparam int MaxDigitsDef = 8;
  localparam int ValueBitsDef = 32;

  localparam int InDataW  = 64;
  localparam int OutDataW = 40;

  localparam logic [1:0] CmdAdd     = 2'd0;
  localparam logic [1:0] CmdRestart = 2'd1;
  localparam logic [1:0] CmdNext    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_END   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_RST_RD,
    S_RST_WR,
    S_CAR_RD,
    S_CAR_WR,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  typedef struct packed {
    logic        load;
    status_e     status;
    logic [2:0]  index;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/mro_ram.sv =====
// ----------------------------------------------------------------------------
// mro_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mro_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  parameter int AddrW = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/mro_ctrl.sv =====
// ----------------------------------------------------------------------------
// mro_ctrl
// Command sequencer: range append, restart sweep, carry walk and digit emit.
// ----------------------------------------------------------------------------
`default_nettype none

module mro_ctrl import mro_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDef,
  parameter int ValueBits = ValueBitsDef,
  parameter int IdxW      = 3,
  parameter int CntW      = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [31:0]            range_low_i,
  input  wire logic [31:0]            range_high_i,
  input  wire logic                   out_free_i,
  output res_t                        res_o,
  output logic                        bnd_we_o,
  output logic [IdxW-1:0]             bnd_waddr_o,
  output logic [2*ValueBits-1:0]      bnd_wdata_o,
  input  wire logic [2*ValueBits-1:0] bnd_rdata_i,
  output logic                        dig_we_o,
  output logic [ValueBits-1:0]        dig_wdata_o,
  input  wire logic [ValueBits-1:0]   dig_rdata_i,
  output logic [IdxW-1:0]             raddr_o
);

  state_e         state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           armed_q, armed_d;
  status_e        st_q, st_d;

  logic                   accept;
  logic [ValueBits+31:0]  lo_ext, hi_ext, val_ext;
  logic [ValueBits-1:0]   lo_v, hi_v, b_lo, b_hi, inc;
  logic [CntW-1:0]        idx_nx;
  logic [IdxW+2:0]        idx_ext;
  logic                   idx_last, order_bad, full, ge;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign lo_ext    = {{ValueBits{range_low_i[31]}}, range_low_i};
  assign hi_ext    = {{ValueBits{range_high_i[31]}}, range_high_i};
  assign lo_v      = lo_ext[ValueBits-1:0];
  assign hi_v      = hi_ext[ValueBits-1:0];
  assign order_bad = $signed(lo_v) > $signed(hi_v);
  assign full      = cnt_q == CntW'(MaxDigits);
  assign b_lo      = bnd_rdata_i[ValueBits-1:0];
  assign b_hi      = bnd_rdata_i[2*ValueBits-1:ValueBits];
  assign ge        = $signed(dig_rdata_i) >= $signed(b_hi);
  assign inc       = dig_rdata_i + ValueBits'(1);
  assign idx_nx    = CntW'(idx_q) + CntW'(1);
  assign idx_last  = idx_nx == cnt_q;
  assign idx_ext   = {3'b000, idx_q};
  assign val_ext   = {32'd0, dig_rdata_i};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CmdRestart: state_d = (cnt_q == '0) ? S_RESP : S_RST_RD;
            CmdNext: begin
              if (cnt_q == '0) begin
                state_d = S_RESP;
              end else begin
                state_d = armed_q ? S_EMIT_RD : S_CAR_RD;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_RST_RD:  state_d = S_RST_WR;
      S_RST_WR:  state_d = idx_last ? S_RESP : S_RST_RD;
      S_CAR_RD:  state_d = S_CAR_WR;
      S_CAR_WR:  state_d = (!ge || idx_last) ? S_EMIT_RD : S_CAR_RD;
      S_EMIT_RD: state_d = S_EMIT_WR;
      S_EMIT_WR: begin
        if (out_free_i) begin
          state_d = idx_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    armed_d     = armed_q;
    st_d        = st_q;
    in_ready_o  = state_q == S_IDLE;
    bnd_we_o    = 1'b0;
    bnd_waddr_o = cnt_q[IdxW-1:0];
    bnd_wdata_o = {hi_v, lo_v};
    dig_we_o    = 1'b0;
    dig_wdata_o = b_lo;
    raddr_o     = idx_q;
    res_o       = '{load: 1'b0, status: st_q, index: 3'd0, value: 32'd0, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          st_d  = ST_OK;
          unique case (cmd_i)
            CmdAdd: begin
              if (order_bad) begin
                st_d = ST_ORDER;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                bnd_we_o = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
              end
            end
            CmdRestart: armed_d = 1'b1;
            CmdNext: begin
              if (armed_q) begin
                armed_d = 1'b0;
              end else if (cnt_q == '0) begin
                st_d = ST_END;
              end
            end
            default: st_d = ST_OK;
          endcase
        end
      end
      S_RST_WR: begin
        dig_we_o = 1'b1;
        if (!idx_last) begin
          idx_d = idx_nx[IdxW-1:0];
        end
      end
      S_CAR_WR: begin
        dig_we_o = 1'b1;
        if (ge) begin
          dig_wdata_o = b_lo;
          if (idx_last) begin
            st_d  = ST_END;
            idx_d = '0;
          end else begin
            idx_d = idx_nx[IdxW-1:0];
          end
        end else begin
          dig_wdata_o = inc;
          idx_d       = '0;
        end
      end
      S_EMIT_WR: begin
        if (out_free_i) begin
          res_o = '{load: 1'b1, status: st_q, index: idx_ext[2:0],
                    value: val_ext[31:0], last: idx_last};
          idx_d = idx_last ? '0 : idx_nx[IdxW-1:0];
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
        end
      end
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mixed_radix_range_odometer.sv =====
// ----------------------------------------------------------------------------
// mixed_radix_range_odometer
// Odometer over a table of signed digit ranges held in block RAM.
// ----------------------------------------------------------------------------
// Requests enter on s_axis: add a range, restart the odometer, or step to
// the next combination; tuser carries the command, tdata the bounds of a
// new range. Results leave on m_axis, one per add, restart or undefined
// request, one per digit for next, tlast on the final one; tuser
// carries the status (ok, order error, table full, end of combinations).
// One request is taken at a time; s_axis_tready is high only when the
// sequencer is idle. Add and undefined requests go straight to a response;
// restart sweeps the stored ranges, setting each digit to its low bound;
// next walks the carry up from digit 0 (no walk on the first next after
// restart), then emits every digit; a next with no ranges stored gives a
// single result. The bound and digit RAMs have a registered read, so each
// digit swept, walked or emitted takes a read state and a write or output
// state. A result shows on m_axis in the cycle after the sequencer loads it.
// Reset clears the range count and the first flag; the RAMs need no pass.
// A result waits in the output register while m_axis_tready is low; the
// sequencer holds until that register is free, no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_range_odometer import mro_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDef,
  parameter int ValueBits = ValueBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // range_low [31:0], range_high [63:32]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // digit_index [2:0], digit_value [34:3], zero fill
  output logic [OutDataW-1:0]      m_axis_tdata,
  // status [1:0]
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  localparam int IdxW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int CntW = $clog2(MaxDigits + 1);

  res_t                    res;
  logic                    out_free;
  logic                    bnd_we, dig_we;
  logic [IdxW-1:0]         bnd_waddr, raddr;
  logic [2*ValueBits-1:0]  bnd_wdata, bnd_rdata;
  logic [ValueBits-1:0]    dig_wdata, dig_rdata;

  logic                    m_valid_q;
  logic [OutDataW-1:0]     m_data_q;
  logic [1:0]              m_user_q;
  logic                    m_last_q;
  logic                    err_res;

  assign out_free = !m_valid_q || m_axis_tready;

  mro_ctrl #(
    .MaxDigits (MaxDigits),
    .ValueBits (ValueBits),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .range_low_i  (s_axis_tdata[31:0]),
    .range_high_i (s_axis_tdata[63:32]),
    .out_free_i   (out_free),
    .res_o        (res),
    .bnd_we_o     (bnd_we),
    .bnd_waddr_o  (bnd_waddr),
    .bnd_wdata_o  (bnd_wdata),
    .bnd_rdata_i  (bnd_rdata),
    .dig_we_o     (dig_we),
    .dig_wdata_o  (dig_wdata),
    .dig_rdata_i  (dig_rdata),
    .raddr_o      (raddr)
  );

  mro_ram #(
    .Width (2 * ValueBits),
    .Depth (MaxDigits),
    .AddrW (IdxW)
  ) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (bnd_waddr),
    .wdata_i (bnd_wdata),
    .raddr_i (raddr),
    .rdata_o (bnd_rdata)
  );

  mro_ram #(
    .Width (ValueBits),
    .Depth (MaxDigits),
    .AddrW (IdxW)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (dig_we),
    .waddr_i (raddr),
    .wdata_i (dig_wdata),
    .raddr_i (raddr),
    .rdata_o (dig_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      m_data_q <= {5'd0, res.value, res.index};
      m_user_q <= res.status;
      m_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  assign err_res = (m_axis_tuser == ST_ORDER) || (m_axis_tuser == ST_FULL);

`include "mixed_radix_range_odometer_assert.svh"

  `MRO_ASSERT(a_load_into_free, res.load |-> out_free)
  `MRO_ASSERT(a_no_load_when_idle, s_axis_tready |-> !res.load)
  `MRO_ASSERT(a_error_single, m_axis_tvalid && err_res |-> m_axis_tlast && m_axis_tdata == '0)

endmodule

`default_nettype wire

// ===== tb/mixed_radix_range_odometer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mixed_radix_range_odometer_checker
// Watches both stream channels of the odometer, keeps its own copy of the
// range table, the digits and the first flag, works out the results of each
// accepted request and compares every result leaving the block with the
// oldest one still waiting, field by field.
// ----------------------------------------------------------------------------
module mixed_radix_range_odometer_checker import mro_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [1:0]          m_axis_tuser,
  input  logic                m_axis_tlast,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output int                  wraps_seen
);

  typedef struct packed {
    status_e     status;
    logic [2:0]  index;
    logic [31:0] value;
    logic        last;
  } odo_result_t;

  odo_result_t        expected_q[$];
  logic signed [31:0] low_bound  [MaxDigits];
  logic signed [31:0] high_bound [MaxDigits];
  logic signed [31:0] digit_val  [MaxDigits];
  int                 ranges_held;
  bit                 first_pending;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    wraps_seen   = 0;
  end

  task automatic push_result(input status_e st, input logic [2:0] idx,
                             input logic [31:0] val, input logic last);
    odo_result_t r;
    r.status = st;
    r.index  = idx;
    r.value  = val;
    r.last   = last;
    expected_q.push_back(r);
  endtask

  task automatic predict_request(input logic [1:0] cmd, input logic signed [31:0] lo,
                                 input logic signed [31:0] hi);
    status_e st;
    bit      carry;
    int      i;
    st    = ST_OK;
    carry = 1'b1;
    case (cmd)
      CmdAdd: begin
        if (lo > hi) begin
          push_result(ST_ORDER, 3'd0, 32'd0, 1'b1);
        end else if (ranges_held >= MaxDigits) begin
          push_result(ST_FULL, 3'd0, 32'd0, 1'b1);
        end else begin
          low_bound[ranges_held]  = lo;
          high_bound[ranges_held] = hi;
          ranges_held++;
          push_result(ST_OK, 3'd0, 32'd0, 1'b1);
        end
      end
      CmdRestart: begin
        for (i = 0; i < ranges_held; i++) digit_val[i] = low_bound[i];
        first_pending = 1'b1;
        push_result(ST_OK, 3'd0, 32'd0, 1'b1);
      end
      CmdNext: begin
        if (first_pending) begin
          first_pending = 1'b0;
        end else begin
          // step digit 0 and carry upward, wrapping each digit past its high bound
          for (i = 0; i < ranges_held && carry; i++) begin
            if (digit_val[i] >= high_bound[i]) begin
              digit_val[i] = low_bound[i];
            end else begin
              digit_val[i] = digit_val[i] + 32'sd1;
              carry = 1'b0;
            end
          end
          if (carry) st = ST_END;
        end
        if (ranges_held == 0) begin
          push_result(st, 3'd0, 32'd0, 1'b1);
        end else begin
          for (i = 0; i < ranges_held; i++)
            push_result(st, 3'(i), digit_val[i], i == ranges_held - 1);
        end
      end
      default: begin
        push_result(ST_OK, 3'd0, 32'd0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    odo_result_t want;
    if (!rst_ni) begin
      ranges_held   = 0;
      first_pending = 1'b0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d index %0d value 0x%0h",
                 m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3]);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("digit_index", want.index, m_axis_tdata[2:0]);
          check_field("digit_value", want.value, m_axis_tdata[34:3]);
          check_field("last", want.last, m_axis_tlast);
          results_seen++;
          if (want.status == ST_END && want.last) wraps_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/mixed_radix_range_odometer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mixed_radix_range_odometer_tb
// Drives add, restart, next and undefined requests into the odometer: a
// directed opening over the bound extremes, order errors and a
// complete wrap, then random traffic built from small ranges so that the
// odometer wraps often. Both sides idle at random; once the result side
// holds off long enough to stall the request side.
// ----------------------------------------------------------------------------
module mixed_radix_range_odometer_tb;
  import mro_pkg::*;

  localparam logic [1:0]         CmdUndef    = 2'd3;
  localparam int                 MaxDigits   = MaxDigitsDef;
  localparam int                 RandomReqs  = 133;
  localparam int                 HoldCycles  = 250;
  localparam int                 DrainCycles = 40;
  localparam logic signed [31:0] ValMax      = 32'sh7fffffff;
  localparam logic signed [31:0] ValMin      = 32'sh80000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  int fail_count, pending, results_seen, wraps_seen;
  int reqs_done, burst_left, ranges_added;
  int n_add, n_restart, n_next, n_undef;
  bit stale_digits, pressure_done;

  mixed_radix_range_odometer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mixed_radix_range_odometer_checker #(.MaxDigits(MaxDigits)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .wraps_seen    (wraps_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // track whether all digits are loaded, so that next never reads a stale one
  task automatic issue(input logic [1:0] cmd, input logic signed [31:0] lo,
                       input logic signed [31:0] hi);
    int gap;
    case (cmd)
      CmdAdd: begin
        n_add++;
        if (lo <= hi && ranges_added < MaxDigits) begin
          ranges_added++;
          stale_digits = 1'b1;
        end
      end
      CmdRestart: begin
        n_restart++;
        stale_digits = 1'b0;
      end
      CmdNext: n_next++;
      default: n_undef++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) burst_left = 20;
      gap = ($urandom_range(0, 99) < 50) ? 0 : idle_len();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    reqs_done++;
    @(negedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      int len;
      @(negedge clk_i);
      if (reqs_done >= 60 && !pressure_done) begin
        pressure_done = 1'b1;
        m_axis_tready <= 1'b0;
        len = HoldCycles;
      end else if ($urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        len = idle_len();
      end else begin
        m_axis_tready <= 1'b1;
        len = ($urandom_range(0, 99) < 5) ? 60 : $urandom_range(1, 12);
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  initial begin
    int                 r, w;
    logic signed [31:0] lo, hi, tmp;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(CmdNext, 32'sd0, 32'sd0);
    issue(CmdRestart, 32'sd0, 32'sd0);
    issue(CmdNext, 32'sd0, 32'sd0);
    issue(CmdUndef, ValMax, ValMin);
    issue(CmdAdd, ValMax, ValMin);
    issue(CmdAdd, 32'sd1, 32'sd0);
    issue(CmdAdd, ValMax - 32'sd1, ValMax);
    issue(CmdAdd, ValMin, ValMin);
    issue(CmdAdd, -32'sd1, 32'sd0);
    issue(CmdAdd, 32'sd0, 32'sd0);
    issue(CmdRestart, 32'sd0, 32'sd0);
    repeat (6) issue(CmdNext, 32'sd0, 32'sd0);

    for (int k = 0; k < RandomReqs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        issue(stale_digits ? CmdRestart : CmdNext, $urandom, $urandom);
      end else if (r < 64) begin
        issue(CmdRestart, $urandom, $urandom);
      end else if (r < 67) begin
        issue(CmdUndef, $urandom, $urandom);
      end else if (r < 90 && ranges_added < MaxDigits) begin
        case ($urandom_range(0, 7))
          0: lo = ValMin;
          1: lo = ValMax;
          2: lo = -32'sd1;
          3: lo = 32'sd0;
          default: lo = $urandom;
        endcase
        w  = $urandom_range(0, 99);
        w  = (w < 70) ? 0 : (w < 95) ? 1 : 2;
        hi = (lo > ValMax - w) ? ValMax : lo + w;
        issue(CmdAdd, lo, hi);
      end else begin
        lo = $urandom;
        hi = $urandom;
        // keep the table free of wide ranges while it still has room
        if (ranges_added < MaxDigits && lo < hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        issue(CmdAdd, lo, hi);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d requests: %0d add, %0d restart, %0d next, %0d undefined",
             reqs_done, n_add, n_restart, n_next, n_undef);
    $display("checked %0d results, %0d of them closing a full wrap of the odometer",
             results_seen, wraps_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mixed_radix_range_odometer.f =====
+incdir+src
src/mro_pkg.sv
src/mro_ram.sv
src/mro_ctrl.sv
src/mixed_radix_range_odometer.sv
tb/mixed_radix_range_odometer_checker.sv
tb/mixed_radix_range_odometer_tb.sv
